FILE: design/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg: shared constants and saturating arithmetic
// Word format, golden-ratio constant, result codes and helpers used by the
// golden-section search controller.
// ----------------------------------------------------------------------------
package gss_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 24;
	localparam int TOL_W     = WORD_W - 1;
	localparam int COUNT_W   = 8;
	localparam int CFG_IDX_W = 2;

	// (3 - sqrt(5)) / 2 as unsigned Q0.32
	localparam logic [WORD_W-1:0] GOLD_Q32 = 32'h61C8_8647;

	// reset bounds: left -2.0, right 0, tolerance 17 lsb
	localparam logic signed [WORD_W-1:0] LEFT_RESET  = WORD_W'(-(2 <<< FRAC_BITS));
	localparam logic signed [WORD_W-1:0] RIGHT_RESET = '0;
	localparam logic [TOL_W-1:0]         TOL_RESET   = TOL_W'(17);

	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;

	// request opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_PROBE   = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd2;

	function automatic logic signed [WORD_W-1:0] sat_add(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_sub(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	// floor((a + b) / 2), no overflow
	function automatic logic signed [WORD_W-1:0] midpoint(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		return s[WORD_W:1];
	endfunction

endpackage

FILE: design/golden_section_search.sv
// ----------------------------------------------------------------------------
// golden_section_search: golden-section maximum search controller
// Emits probe abscissas in signed Q8.24, takes back objective values from an
// external evaluator, narrows the interval and reports its midpoint.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | opcode, objective_value
//  out     | out_valid/out_stall | status, probe_point, extremum, eval_count
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  From accept to result: the input register, then one pass of compare /
//  saturating add / golden multiply into the result register.
//  One request per cycle sustained unless out_stall holds back a result; the
//  state update of a request is done in the cycle it moves from the input
//  register into the result register. in_stall rises only when the input
//  register is full and the result register holds a result under out_stall.
//  Reset clears the pipeline, sets the search idle and loads the default
//  bounds (-2.0, 0) and tolerance (17 lsb).
//
module golden_section_search (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [gss_pkg::WORD_W-1:0]   objective_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [gss_pkg::WORD_W-1:0]   probe_point,
	output logic signed [gss_pkg::WORD_W-1:0]   extremum,
	output logic [gss_pkg::COUNT_W-1:0]         eval_count,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gss_pkg::WORD_W-1:0]          cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST_LOW,
		PH_WAIT_HIGH,
		PH_WAIT_LOW
	} phase_t;

	// config registers
	logic signed [gss_pkg::WORD_W-1:0] left_bound_q;
	logic signed [gss_pkg::WORD_W-1:0] right_bound_q;
	logic [gss_pkg::TOL_W-1:0]         tolerance_q;

	// input stage
	logic                              valid_s1;
	logic                              opcode_s1;
	logic signed [gss_pkg::WORD_W-1:0] value_s1;
	logic signed [gss_pkg::WORD_W-1:0] width_s1;   // right - left of the bounds

	// search state
	phase_t                            phase_q, phase_d;
	logic [gss_pkg::COUNT_W-1:0]       evals_q, evals_d;
	logic signed [gss_pkg::WORD_W-1:0] left_q, left_d;
	logic signed [gss_pkg::WORD_W-1:0] right_q, right_d;
	logic signed [gss_pkg::WORD_W-1:0] low_pt_q, low_pt_d;
	logic signed [gss_pkg::WORD_W-1:0] high_pt_q, high_pt_d;
	logic signed [gss_pkg::WORD_W-1:0] low_val_q, low_val_d;
	logic signed [gss_pkg::WORD_W-1:0] high_val_q, high_val_d;

	// result register
	logic                              out_valid_q;
	logic [1:0]                        status_q, res_status;
	logic signed [gss_pkg::WORD_W-1:0] probe_q, res_probe;
	logic signed [gss_pkg::WORD_W-1:0] ext_q, res_ext;
	logic [gss_pkg::COUNT_W-1:0]       count_q, res_count;

	logic                              advance;
	logic signed [gss_pkg::WORD_W-1:0] first_probe;
	logic [gss_pkg::COUNT_W-1:0]       evals_inc;

	// decision datapath
	logic signed [gss_pkg::WORD_W-1:0] low_v, high_v;
	logic                              low_gt;
	logic signed [gss_pkg::WORD_W-1:0] new_l, new_r, kept;
	logic signed [gss_pkg::WORD_W-1:0] new_width, mirror;
	logic                              narrow;

	// ---------------- config ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_bound_q  <= gss_pkg::LEFT_RESET;
			right_bound_q <= gss_pkg::RIGHT_RESET;
			tolerance_q   <= gss_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gss_pkg::REG_LEFT:  left_bound_q  <= cfg_data;
				gss_pkg::REG_RIGHT: right_bound_q <= cfg_data;
				gss_pkg::REG_TOL:   tolerance_q   <= cfg_data[gss_pkg::TOL_W-1:0];
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	// ---------------- input stage ----------------
	// the result register takes a new result when empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// the user must keep the bounds static while a request is in flight (not
	// enforced); taking the width here keeps the multiplier off the subtract
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			value_s1  <= objective_value;
			width_s1  <= gss_pkg::sat_sub(right_bound_q, left_bound_q);
		end
	end

	gss_gold_probe u_gold (
		.width (width_s1),
		.base  (left_bound_q),
		.probe (first_probe)
	);

	// ---------------- decision ----------------
	assign evals_inc = (evals_q == gss_pkg::COUNT_MAX) ? evals_q : evals_q + 1'b1;

	// the fresh value replaces the inner point that was just probed
	assign low_v  = (phase_q == PH_WAIT_LOW)  ? value_s1 : low_val_q;
	assign high_v = (phase_q == PH_WAIT_HIGH) ? value_s1 : high_val_q;
	assign low_gt = low_v > high_v;

	// low side greater: drop [high, right]; otherwise drop [left, low].
	// The first high probe mirrors the low one inside the full interval.
	always_comb begin
		if (phase_q == PH_FIRST_LOW || low_gt) begin
			new_l = left_q;
			new_r = (phase_q == PH_FIRST_LOW) ? right_q : high_pt_q;
			kept  = low_pt_q;
		end else begin
			new_l = low_pt_q;
			new_r = right_q;
			kept  = high_pt_q;
		end
	end

	assign new_width = gss_pkg::sat_sub(new_r, new_l);
	assign narrow    = $signed({new_width[gss_pkg::WORD_W-1], new_width})
	                 < $signed({2'b00, tolerance_q});
	assign mirror    = gss_pkg::sat_sub(gss_pkg::sat_add(new_l, new_r), kept);

	always_comb begin
		phase_d    = phase_q;
		evals_d    = evals_q;
		left_d     = left_q;
		right_d    = right_q;
		low_pt_d   = low_pt_q;
		high_pt_d  = high_pt_q;
		low_val_d  = low_val_q;
		high_val_d = high_val_q;
		res_status = gss_pkg::ST_IGNORED;
		res_probe  = '0;
		res_ext    = '0;
		res_count  = evals_q;

		if (opcode_s1 == gss_pkg::OP_START) begin
			// start always wins, even over a running search
			left_d     = left_bound_q;
			right_d    = right_bound_q;
			low_pt_d   = first_probe;
			high_pt_d  = '0;
			low_val_d  = '0;
			high_val_d = '0;
			evals_d    = gss_pkg::COUNT_W'(1);
			phase_d    = PH_FIRST_LOW;
			res_status = gss_pkg::ST_PROBE;
			res_probe  = first_probe;
			res_count  = gss_pkg::COUNT_W'(1);
		end else begin
			unique case (phase_q) inside
				PH_IDLE: begin
					// value with no search running
				end
				PH_FIRST_LOW: begin
					low_val_d  = value_s1;
					high_pt_d  = mirror;
					phase_d    = PH_WAIT_HIGH;
					evals_d    = evals_inc;
					res_status = gss_pkg::ST_PROBE;
					res_probe  = mirror;
					res_count  = evals_inc;
				end
				PH_WAIT_HIGH, PH_WAIT_LOW: begin
					low_val_d  = low_v;
					high_val_d = high_v;
					left_d     = new_l;
					right_d    = new_r;
					if (narrow) begin
						phase_d    = PH_IDLE;
						res_status = gss_pkg::ST_DONE;
						res_ext    = gss_pkg::midpoint(new_l, new_r);
					end else begin
						if (low_gt) begin
							high_pt_d  = low_pt_q;
							high_val_d = low_v;
							low_pt_d   = mirror;
							phase_d    = PH_WAIT_LOW;
						end else begin
							low_pt_d   = high_pt_q;
							low_val_d  = high_v;
							high_pt_d  = mirror;
							phase_d    = PH_WAIT_HIGH;
						end
						evals_d    = evals_inc;
						res_status = gss_pkg::ST_PROBE;
						res_probe  = mirror;
						res_count  = evals_inc;
					end
				end
			endcase
		end
	end

	// ---------------- state and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			evals_q     <= '0;
			left_q      <= '0;
			right_q     <= '0;
			low_pt_q    <= '0;
			high_pt_q   <= '0;
			low_val_q   <= '0;
			high_val_q  <= '0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			probe_q     <= '0;
			ext_q       <= '0;
			count_q     <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			evals_q     <= evals_d;
			left_q      <= left_d;
			right_q     <= right_d;
			low_pt_q    <= low_pt_d;
			high_pt_q   <= high_pt_d;
			low_val_q   <= low_val_d;
			high_val_q  <= high_val_d;
			out_valid_q <= 1'b1;
			status_q    <= res_status;
			probe_q     <= res_probe;
			ext_q       <= res_ext;
			count_q     <= res_count;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign probe_point = probe_q;
	assign extremum    = ext_q;
	assign eval_count  = count_q;

endmodule

FILE: design/gss_gold_probe.sv
// ----------------------------------------------------------------------------
// gss_gold_probe: first probe point of a search
// probe = left + round(c * width), c = (3 - sqrt(5)) / 2, rounding half away
// from zero, sum saturated.
// ----------------------------------------------------------------------------
module gss_gold_probe (
	input  logic signed [gss_pkg::WORD_W-1:0] width,
	input  logic signed [gss_pkg::WORD_W-1:0] base,
	output logic signed [gss_pkg::WORD_W-1:0] probe
);

	logic [gss_pkg::WORD_W-1:0]   mag;
	logic [2*gss_pkg::WORD_W-1:0] prod;
	logic [2*gss_pkg::WORD_W-1:0] prod_rnd;
	logic [gss_pkg::WORD_W-1:0]   scaled;
	logic signed [gss_pkg::WORD_W-1:0] term;

	// magnitude; the most negative width maps to 2^(W-1), still fits unsigned
	assign mag      = width[gss_pkg::WORD_W-1] ? gss_pkg::WORD_W'(-width) : width;
	assign prod     = (2*gss_pkg::WORD_W)'(mag) * (2*gss_pkg::WORD_W)'(gss_pkg::GOLD_Q32);
	assign prod_rnd = prod + ((2*gss_pkg::WORD_W)'(1) << (gss_pkg::WORD_W - 1));
	assign scaled   = prod_rnd[2*gss_pkg::WORD_W-1:gss_pkg::WORD_W];
	assign term     = width[gss_pkg::WORD_W-1] ? gss_pkg::WORD_W'(-scaled) : scaled;
	assign probe    = gss_pkg::sat_add(base, term);

endmodule

FILE: design/gss_checker.sv
// ----------------------------------------------------------------------------
// gss_checker: port-level checks for the search controller
// Watches the result channel for held results and consistent result fields.
// ----------------------------------------------------------------------------
module gss_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [1:0]                        status,
	input  logic signed [gss_pkg::WORD_W-1:0] probe_point,
	input  logic signed [gss_pkg::WORD_W-1:0] extremum,
	input  logic [gss_pkg::COUNT_W-1:0]       eval_count
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(probe_point) && $stable(extremum) && $stable(eval_count))
		else $error("result changed under stall");

	// a probe carries no midpoint and counts at least one evaluation
	a_probe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gss_pkg::ST_PROBE |-> extremum == '0 && eval_count != '0)
		else $error("probe result fields inconsistent");

	// a finished search carries no probe and follows at least two evaluations
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gss_pkg::ST_DONE |-> probe_point == '0 && eval_count >= 2)
		else $error("done result fields inconsistent");

	// ignored requests report nothing but the count
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gss_pkg::ST_IGNORED |-> probe_point == '0 && extremum == '0)
		else $error("ignored result carries data");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == gss_pkg::ST_PROBE || status == gss_pkg::ST_DONE
			|| status == gss_pkg::ST_IGNORED)
		else $error("undefined status code");

endmodule

bind golden_section_search gss_checker u_gss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.probe_point (probe_point),
	.extremum    (extremum),
	.eval_count  (eval_count)
);
